FILE: rtl/core/upd_pkg.sv
// Shared types, constants and the hex digit decoder for the URL percent decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package upd_pkg;

  localparam logic [7:0] PctChar = 8'h25;
  localparam int unsigned MaxBytes = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_string_end;
    logic       out_run_end;
  } out_item_t;

  // one input item's worth of output bytes, 1..3 of them
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [1:0]               count;
    logic                     str_end;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok = 1'b1;
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/url_percent_decoder.sv
// Top level of the URL percent decoder: front end, job queue and back end.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+----------------------
//   in      | to block  | in_item_t   | in_valid / in_stall
//   out     | from block| out_item_t  | out_valid / out_stall
//
// An input item is taken every cycle while the job queue has room; it yields
// 0 to 3 output bytes, which leave one per cycle while out_stall is low. The
// four-entry job queue absorbs those bursts. Output leaves from a register
// loaded from the queue head. Reset (synchronous, rst high) empties the queue
// and drops any held escape. in_stall rises only when the queue is full.
`default_nettype none

module url_percent_decoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire upd_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output upd_pkg::out_item_t      out_item
);

  logic               push, pop;
  upd_pkg::job_t      push_job, head;
  upd_pkg::q_status_t q_status;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  upd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: rtl/core/upd_front.sv
// Front end: accepts input items, tracks the pending escape and builds output jobs.
// Depends on upd_pkg.
`default_nettype none

module upd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire upd_pkg::in_item_t in_item,
  input  wire upd_pkg::q_status_t q_status,
  output logic                   push,
  output upd_pkg::job_t          push_job
);

  localparam logic [1:0] HeldNone  = 2'd0;
  localparam logic [1:0] HeldPct   = 2'd1;
  localparam logic [1:0] HeldDigit = 2'd2;

  logic [1:0]    held_count, held_count_next;
  logic [7:0]    held_digit, held_digit_next;
  upd_pkg::job_t job;
  upd_pkg::hex_t lo, hi;
  logic          accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [1:0] cnt;
    logic [7:0] b;
    cnt             = 2'd0;
    b               = in_item.in_byte;
    lo              = upd_pkg::hex_decode(b);
    hi              = upd_pkg::hex_decode(held_digit);
    held_count_next = held_count;
    held_digit_next = held_digit;
    job             = '0;

    case (held_count)
      HeldPct: begin
        if (lo.ok) begin
          held_digit_next = b;
          held_count_next = HeldDigit;
        end else begin
          job.bytes[cnt] = upd_pkg::PctChar;
          cnt = cnt + 2'd1;
          if (b == upd_pkg::PctChar) begin
            held_count_next = HeldPct;
          end else begin
            held_count_next = HeldNone;
            job.bytes[cnt] = b;
            cnt = cnt + 2'd1;
          end
        end
      end
      HeldDigit: begin
        if (lo.ok) begin
          held_count_next = HeldNone;
          job.bytes[cnt] = {hi.val, lo.val};
          cnt = cnt + 2'd1;
        end else begin
          job.bytes[cnt] = upd_pkg::PctChar;
          cnt = cnt + 2'd1;
          job.bytes[cnt] = held_digit;
          cnt = cnt + 2'd1;
          if (b == upd_pkg::PctChar) begin
            held_count_next = HeldPct;
          end else begin
            held_count_next = HeldNone;
            job.bytes[cnt] = b;
            cnt = cnt + 2'd1;
          end
        end
      end
      default: begin
        if (b == upd_pkg::PctChar) begin
          held_count_next = HeldPct;
        end else begin
          held_count_next = HeldNone;
          job.bytes[cnt] = b;
          cnt = cnt + 2'd1;
        end
      end
    endcase

    // flush whatever is still held at end of string
    if (in_item.in_last) begin
      if (held_count_next == HeldPct || held_count_next == HeldDigit) begin
        job.bytes[cnt] = upd_pkg::PctChar;
        cnt = cnt + 2'd1;
      end
      if (held_count_next == HeldDigit) begin
        job.bytes[cnt] = held_digit_next;
        cnt = cnt + 2'd1;
      end
      held_count_next = HeldNone;
      held_digit_next = 8'h00;
    end

    job.count   = cnt;
    job.str_end = in_item.in_last;
  end

  assign push     = accept && (job.count != 2'd0);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HeldNone;
      held_digit <= 8'h00;
    end else if (accept) begin
      held_count <= held_count_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/upd_queue.sv
// Short job queue between the front end and the back end.
// Depends on upd_pkg.
`default_nettype none

module upd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire upd_pkg::job_t push_job,
  input  wire logic          pop,
  output upd_pkg::job_t      head,
  output upd_pkg::q_status_t status
);

  localparam int unsigned CntW = $clog2(upd_pkg::QueueDepth + 1);

  upd_pkg::job_t                   mem [upd_pkg::QueueDepth];
  logic [upd_pkg::QueuePtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]                 count;
  logic                            do_push, do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == CntW'(upd_pkg::QueueDepth));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/upd_back.sv
// Back end: walks the head job one byte per cycle, while out_stall is low, into the output register.
// Depends on upd_pkg.
`default_nettype none

module upd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire upd_pkg::job_t      head,
  input  wire upd_pkg::q_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output upd_pkg::out_item_t      out_item
);

  logic [1:0] idx;
  logic       load, last_of_job;

  assign load        = !out_valid || !out_stall;
  assign last_of_job = ((idx + 2'd1) == head.count);
  assign pop         = load && !q_status.empty && last_of_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= !q_status.empty;
      if (!q_status.empty) begin
        idx <= last_of_job ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load && !q_status.empty) begin
      out_item.out_byte       <= head.bytes[idx];
      out_item.out_string_end <= last_of_job && head.str_end;
      out_item.out_run_end    <= last_of_job;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/upd_checker.sv
// Port-level checks for the URL percent decoder, bound to the top level.
// Depends on upd_pkg and url_percent_decoder.
`default_nettype none

module upd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire upd_pkg::out_item_t out_item
);

  // a waiting result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output changed while stalled");

  // the end of a string is always the end of that item's run
  a_str_end_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.out_string_end |-> out_item.out_run_end)
    else $error("string end without run end");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // nothing is valid at the output when rst has just fallen
  a_no_early_out: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("output valid in first cycle after reset");

endmodule

bind url_percent_decoder upd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
